[rtl/utf8_char_segmenter_top_assert.svh]
// Assertion macros used by the segmenter checker.
// Each macro expects clk and rst to be visible where it is used.
`ifndef UTF8_CHAR_SEGMENTER_TOP_ASSERT_SVH
`define UTF8_CHAR_SEGMENTER_TOP_ASSERT_SVH

// Same-cycle implication.
`define UTF8S_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8 segmenter check failed");

// Next-cycle implication.
`define UTF8S_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8 segmenter check failed");

`endif

[rtl/utf8s_pkg.sv]
package utf8s_pkg;

  localparam logic [7:0] BYTE_CR    = 8'h0d;
  localparam logic [7:0] BYTE_LF    = 8'h0a;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] LEAD2_LO   = 8'hc2;
  localparam logic [7:0] LEAD2_HI   = 8'hdf;
  localparam logic [7:0] LEAD3_LO   = 8'he0;
  localparam logic [7:0] LEAD3_HI   = 8'hef;
  localparam logic [7:0] LEAD4_LO   = 8'hf0;
  localparam logic [7:0] LEAD4_HI   = 8'hf4;
  localparam logic [7:0] BAD_LO     = 8'h80;
  localparam logic [7:0] BAD_HI     = 8'hc1;
  localparam logic [7:0] BAD_TOP    = 8'hf5;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [31:0] char_bytes;
    logic [2:0]  char_length;
    logic        valid_lead;
    logic        end_of_line;
    logic        is_blank;
    logic        truncated;
    logic [31:0] char_index;
    logic        stream_done;
    logic        last_of_run;
  } res_t;

  // Results produced by one accepted byte, in order.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd1;
    if (b >= LEAD2_LO && b <= LEAD2_HI) len = 3'd2;
    else if (b >= LEAD3_LO && b <= LEAD3_HI) len = 3'd3;
    else if (b >= LEAD4_LO && b <= LEAD4_HI) len = 3'd4;
    return len;
  endfunction

  function automatic logic lead_ok(input logic [7:0] b);
    return !((b >= BAD_LO && b <= BAD_HI) || b >= BAD_TOP);
  endfunction

  function automatic res_t make_res(input logic [31:0] bytes, input logic [2:0] len,
                                    input logic trunc, input logic done,
                                    input logic [31:0] idx, input logic last);
    res_t r;
    r.char_bytes  = bytes;
    r.char_length = len;
    r.valid_lead  = lead_ok(bytes[7:0]);
    r.end_of_line = (bytes[7:0] == BYTE_CR) &&
                    (len == 3'd1 || (len == 3'd2 && bytes[15:8] == BYTE_LF));
    r.is_blank    = (bytes[7:0] == BYTE_SPACE) && (len == 3'd1);
    r.truncated   = trunc;
    r.char_index  = idx;
    r.stream_done = done;
    r.last_of_run = last;
    return r;
  endfunction

endpackage

[rtl/utf8s_core.sv]
module utf8s_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           byte_value,
  input  logic                 end_of_stream,
  output utf8s_pkg::push_t     push
);
  import utf8s_pkg::*;

  logic [23:0] collected_bytes, collected_bytes_next;
  logic [1:0]  collected_count, collected_count_next;
  logic [2:0]  expected_length, expected_length_next;
  logic        cr_waiting, cr_waiting_next;
  logic [31:0] char_counter, char_counter_next;

  logic        lead_emit, lead_hold_cr, lead_collect;
  logic [31:0] lead_bytes;
  logic [2:0]  lead_length;
  logic        lead_trunc;
  logic [2:0]  len_of_byte;

  logic [1:0]  n;
  logic [31:0] f_bytes, s_bytes;
  logic [2:0]  f_len, s_len;
  logic        f_trunc, s_trunc, f_done, s_done;
  logic [2:0]  cnt_inc;
  logic [31:0] merged;

  assign len_of_byte = lead_len(byte_value);

  // Outcome of taking the current byte as a lead byte.
  always_comb begin
    lead_emit    = 1'b0;
    lead_hold_cr = 1'b0;
    lead_collect = 1'b0;
    lead_bytes   = {24'd0, byte_value};
    lead_length  = len_of_byte;
    lead_trunc   = 1'b0;
    if (byte_value == BYTE_CR) begin
      lead_length = 3'd1;
      if (end_of_stream) lead_emit = 1'b1;
      else lead_hold_cr = 1'b1;
    end else if (len_of_byte == 3'd1) begin
      lead_emit = 1'b1;
    end else if (end_of_stream) begin
      lead_emit  = 1'b1;
      lead_trunc = 1'b1;
    end else begin
      lead_collect = 1'b1;
    end
  end

  always_comb begin
    n       = 2'd0;
    f_bytes = lead_bytes;
    f_len   = lead_length;
    f_trunc = lead_trunc;
    f_done  = end_of_stream;
    s_bytes = lead_bytes;
    s_len   = lead_length;
    s_trunc = lead_trunc;
    s_done  = end_of_stream;
    cnt_inc = {1'b0, collected_count} + 3'd1;
    merged  = {8'd0, collected_bytes} | ({24'd0, byte_value} << {collected_count, 3'b000});

    collected_bytes_next = collected_bytes;
    collected_count_next = collected_count;
    expected_length_next = expected_length;
    cr_waiting_next      = cr_waiting;
    char_counter_next    = char_counter;

    if (cr_waiting) begin
      cr_waiting_next = 1'b0;
      n = 2'd1;
      if (byte_value == BYTE_LF) begin
        f_bytes = {16'd0, BYTE_LF, BYTE_CR};
        f_len   = 3'd2;
        f_trunc = 1'b0;
      end else begin
        // The held CR stands alone; the new byte then starts a character.
        f_bytes = {24'd0, BYTE_CR};
        f_len   = 3'd1;
        f_trunc = 1'b0;
        f_done  = 1'b0;
        if (lead_emit) n = 2'd2;
        if (lead_hold_cr) cr_waiting_next = 1'b1;
        if (lead_collect) begin
          collected_bytes_next = {16'd0, byte_value};
          collected_count_next = 2'd1;
          expected_length_next = len_of_byte;
        end
      end
    end else if (collected_count != 2'd0) begin
      f_bytes = merged;
      f_len   = expected_length;
      if (cnt_inc >= expected_length) begin
        n       = 2'd1;
        f_trunc = 1'b0;
        collected_bytes_next = 24'd0;
        collected_count_next = 2'd0;
        expected_length_next = 3'd1;
      end else if (end_of_stream) begin
        n       = 2'd1;
        f_trunc = 1'b1;
        collected_bytes_next = 24'd0;
        collected_count_next = 2'd0;
        expected_length_next = 3'd1;
      end else begin
        collected_bytes_next = merged[23:0];
        collected_count_next = cnt_inc[1:0];
      end
    end else begin
      if (lead_emit) n = 2'd1;
      if (lead_hold_cr) cr_waiting_next = 1'b1;
      if (lead_collect) begin
        collected_bytes_next = {16'd0, byte_value};
        collected_count_next = 2'd1;
        expected_length_next = len_of_byte;
      end
    end

    char_counter_next = char_counter + {30'd0, n};

    // The end of a stream returns everything to its reset value.
    if (end_of_stream) begin
      collected_bytes_next = 24'd0;
      collected_count_next = 2'd0;
      expected_length_next = 3'd1;
      cr_waiting_next      = 1'b0;
      char_counter_next    = 32'd0;
    end
  end

  always_comb begin
    push.count  = accept ? n : 2'd0;
    push.first  = make_res(f_bytes, f_len, f_trunc, f_done, char_counter, n == 2'd1);
    push.second = make_res(s_bytes, s_len, s_trunc, s_done, char_counter + 32'd1, 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collected_bytes <= 24'd0;
      collected_count <= 2'd0;
      expected_length <= 3'd1;
      cr_waiting      <= 1'b0;
      char_counter    <= 32'd0;
    end else if (accept) begin
      collected_bytes <= collected_bytes_next;
      collected_count <= collected_count_next;
      expected_length <= expected_length_next;
      cr_waiting      <= cr_waiting_next;
      char_counter    <= char_counter_next;
    end
  end

endmodule

[rtl/utf8s_outq.sv]
module utf8s_outq (
  input  logic               clk,
  input  logic               rst,
  input  utf8s_pkg::push_t   push,
  input  logic               pop,
  output logic               has_room,
  output logic               head_valid,
  output utf8s_pkg::res_t    head
);
  import utf8s_pkg::*;

  res_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic [QUEUE_AW:0]   count_after_pop;
  logic [QUEUE_AW-1:0] wr_ptr_plus1;

  assign head_valid      = (count != '0);
  assign head            = entries[rd_ptr];
  assign count_after_pop = count - {{QUEUE_AW{1'b0}}, pop};
  // One byte can yield two results, so a transaction needs two free slots.
  assign has_room        = (count_after_pop <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));
  assign wr_ptr_plus1    = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wr_ptr] <= push.first;
    if (push.count == 2'd2) entries[wr_ptr_plus1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_AW'(push.count);
      rd_ptr <= rd_ptr + {{(QUEUE_AW-1){1'b0}}, pop};
      count  <= count_after_pop + (QUEUE_AW + 1)'(push.count);
    end
  end

endmodule

[rtl/utf8_char_segmenter_top.sv]
// A result is registered in the result queue and offered from the queue's head.
// Throughput: one byte per cycle while the queue has room for two results; a byte
// yielding two results (a held CR, then a non-LF byte emitted at once) queues both.
// The four-entry result queue lets input continue while a result waits.
// Reset (rst, synchronous) empties the queue and clears all character state.
module utf8_char_segmenter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] char_bytes,
  output logic [2:0]  char_length,
  output logic        valid_lead,
  output logic        end_of_line,
  output logic        is_blank,
  output logic        truncated,
  output logic [31:0] char_index,
  output logic        stream_done,
  output logic        last_of_run
);
  import utf8s_pkg::*;

  push_t push;
  res_t  head;
  logic  accept, pop;

  assign accept = in_valid && in_ready;
  assign pop    = out_valid && out_ready;

  utf8s_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .byte_value    (byte_value),
    .end_of_stream (end_of_stream),
    .push          (push)
  );

  utf8s_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .has_room   (in_ready),
    .head_valid (out_valid),
    .head       (head)
  );

  assign char_bytes  = head.char_bytes;
  assign char_length = head.char_length;
  assign valid_lead  = head.valid_lead;
  assign end_of_line = head.end_of_line;
  assign is_blank    = head.is_blank;
  assign truncated   = head.truncated;
  assign char_index  = head.char_index;
  assign stream_done = head.stream_done;
  assign last_of_run = head.last_of_run;

endmodule

[rtl/utf8s_checker.sv]
`include "utf8_char_segmenter_top_assert.svh"

module utf8s_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] char_bytes,
  input logic [2:0]  char_length,
  input logic        end_of_line,
  input logic        is_blank,
  input logic        truncated,
  input logic        stream_done,
  input logic        last_of_run
);
  import utf8s_pkg::*;

  `UTF8S_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(char_bytes))
  `UTF8S_ASSERT_NOW(a_blank_shape, out_valid && is_blank,
                    char_length == 3'd1 && char_bytes == {24'd0, BYTE_SPACE})
  `UTF8S_ASSERT_NOW(a_eol_lead, out_valid && end_of_line, char_bytes[7:0] == BYTE_CR)
  `UTF8S_ASSERT_NOW(a_done_last, out_valid && stream_done, last_of_run)
  `UTF8S_ASSERT_NOW(a_trunc_multi, out_valid && truncated,
                    char_length == 3'd2 || char_length == 3'd3 || char_length == 3'd4)

endmodule

bind utf8_char_segmenter_top utf8s_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .char_bytes  (char_bytes),
  .char_length (char_length),
  .end_of_line (end_of_line),
  .is_blank    (is_blank),
  .truncated   (truncated),
  .stream_done (stream_done),
  .last_of_run (last_of_run)
);
